// File: rtl/dhq_pkg.sv
// dhq_pkg: shared constants, types and controller/datapath command structs
// for the d-ary min-heap queue. No dependencies.
package dhq_pkg;

    localparam int CAPACITY  = 256;
    localparam int MAX_D     = 8;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int COUNT_W   = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 32;
    localparam int D_W       = 4;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [2:0] {
        MEM_NONE   = 3'b001,
        MEM_PARENT = 3'b010,
        MEM_CHILD  = 3'b100
    } mem_rd_sel_t;

    // controller -> datapath
    typedef struct packed {
        logic        load;        // capture command and key
        logic        up_start;    // begin push: pos = count
        logic        rd_parent;   // issue parent read
        logic        up_step;     // evaluate parent data
        logic        dn_start;    // begin pop: capture root, read last entry
        logic        dn_last;     // capture last entry as sift key
        logic        dn_level;    // start a level: child index 0
        logic        rd_child;    // issue child read
        logic        dn_cmp;      // compare child data
        logic        dn_move;     // move best child up a level
        logic        write_key;   // write sift key at pos
        logic        finish;      // register result, update count
    } dhq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_pop;
        logic empty;
        logic full;
        logic at_root;
        logic up_stop;      // parent not greater
        logic last_is_root; // pop leaves heap empty
        logic child_more;   // current child index valid
        logic best_moved;   // some child was smaller
    } dhq_status_t;

    function automatic logic key_less(input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

// File: rtl/dhq_datapath.sv
// dhq_datapath: heap memory, index arithmetic, key compare and result regs.
// Depends on dhq_pkg.
module dhq_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dhq_pkg::dhq_cmd_t           cmd,
    output dhq_pkg::dhq_status_t        status,
    input  logic                        cfg_we,
    input  logic [dhq_pkg::D_W-1:0]     cfg_data,
    input  logic                        command,
    input  logic [dhq_pkg::KEY_W-1:0]   key_in,
    output logic                        result_valid,
    output logic [dhq_pkg::KEY_W-1:0]   key_out,
    output logic                        was_empty,
    output logic                        overflow,
    output logic [dhq_pkg::COUNT_W-1:0] entries_now
);

    localparam int AW = dhq_pkg::ADDR_W;
    localparam int CW = dhq_pkg::COUNT_W;
    localparam int KW = dhq_pkg::KEY_W;
    // wide enough for d*pos+1+c before range check
    localparam int IW = CW + dhq_pkg::D_W + 1;

    logic [KW-1:0] mem [dhq_pkg::CAPACITY];
    logic [KW-1:0] rd_data_reg;

    logic [dhq_pkg::D_W-1:0] dcfg_reg;
    logic [dhq_pkg::D_W-1:0] d_eff;
    logic [CW-1:0] count_reg, count_next;
    logic          is_pop_reg;
    logic [KW-1:0] key_reg;
    logic [KW-1:0] root_reg;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] parent_reg;
    logic [CW-1:0] best_reg;
    logic [KW-1:0] best_key_reg;
    logic [dhq_pkg::D_W-1:0] c_reg;
    logic [IW-1:0] child_idx;
    logic [IW-1:0] base_reg;
    logic [CW-1:0] parent_calc;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [KW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    always_comb
    begin
        if (dcfg_reg < 4'd2)
            d_eff = 4'd2;
        else if (dcfg_reg > dhq_pkg::D_W'(dhq_pkg::MAX_D))
            d_eff = dhq_pkg::D_W'(dhq_pkg::MAX_D);
        else
            d_eff = dcfg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcfg_reg <= 4'd2;
        else if (cfg_we)
            dcfg_reg <= cfg_data;
    end

    // parent = (pos-1)/d: shifts for powers of two, reciprocal multiply
    // otherwise; exact for any 9-bit value
    always_comb
    begin
        logic [CW-1:0] pm1;
        pm1 = pos_reg - CW'(1);
        parent_calc = '0;
        case (d_eff)
            4'd2: parent_calc = pm1 >> 1;
            4'd4: parent_calc = pm1 >> 2;
            4'd8: parent_calc = pm1 >> 3;
            4'd3: parent_calc = CW'((27'(pm1) * 27'd43691) >> 17);
            4'd5: parent_calc = CW'((27'(pm1) * 27'd52429) >> 18);
            4'd6: parent_calc = CW'((27'(pm1) * 27'd43691) >> 18);
            4'd7: parent_calc = CW'((27'(pm1) * 27'd74899) >> 19);
            default: parent_calc = pm1 >> 1;
        endcase
    end

    assign child_idx = base_reg + IW'(c_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            result_valid <= cmd.finish;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.finish)
        begin
            if (!is_pop_reg && count_reg != CW'(dhq_pkg::CAPACITY))
                count_next = count_reg + CW'(1);
            else if (is_pop_reg && count_reg != '0)
                count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.up_start)
            pos_next = count_reg;
        else if (cmd.dn_start)
            pos_next = '0;
        else if (cmd.up_step && !dhq_pkg::key_less(key_reg, rd_data_reg) ||
                 cmd.up_step && pos_reg == '0)
            pos_next = pos_reg;
        else if (cmd.up_step)
            pos_next = parent_reg;
        else if (cmd.dn_move)
            pos_next = best_reg;
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (cmd.load)
        begin
            is_pop_reg <= command;
            key_reg    <= key_in;
        end
        if (cmd.dn_last)
            key_reg <= rd_data_reg;
        if (cmd.rd_parent)
            parent_reg <= parent_calc;
        if (cmd.dn_level)
        begin
            c_reg        <= '0;
            base_reg     <= IW'(pos_reg) * IW'(d_eff) + IW'(1);
            best_reg     <= pos_reg;
            best_key_reg <= key_reg;
        end
        if (cmd.rd_child)
            c_reg <= c_reg + 4'd1;
        if (cmd.dn_cmp && dhq_pkg::key_less(rd_data_reg, best_key_reg))
        begin
            best_key_reg <= rd_data_reg;
            best_reg     <= CW'(child_idx - IW'(1));
        end
        if (cmd.finish)
        begin
            was_empty   <= is_pop_reg && count_reg == '0;
            overflow    <= !is_pop_reg && count_reg == CW'(dhq_pkg::CAPACITY);
            key_out     <= (is_pop_reg && count_reg != '0) ? root_reg : '0;
            entries_now <= count_next;
        end
        if (cmd.dn_start)
            root_reg <= rd_data_reg; // root read issued at load
    end

    // memory port control
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = pos_reg[AW-1:0];
        mem_wdata = key_reg;
        if (cmd.rd_parent)
        begin
            mem_re    = 1'b1;
            mem_raddr = parent_calc[AW-1:0];
        end
        else if (cmd.rd_child)
        begin
            mem_re    = 1'b1;
            mem_raddr = child_idx[AW-1:0];
        end
        else if (cmd.dn_start)
        begin
            mem_re    = 1'b1;
            mem_raddr = AW'(count_reg - CW'(1));
        end
        else if (cmd.load)
        begin
            mem_re    = 1'b1;
            mem_raddr = '0;
        end
        if (cmd.up_step && pos_reg != '0 && dhq_pkg::key_less(key_reg, rd_data_reg))
        begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_reg;
        end
        else if (cmd.dn_move)
        begin
            mem_we    = 1'b1;
            mem_wdata = best_key_reg;
        end
        else if (cmd.write_key)
            mem_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        status.is_pop       = is_pop_reg;
        status.empty        = count_reg == '0;
        status.full         = count_reg == CW'(dhq_pkg::CAPACITY);
        status.at_root      = pos_reg == '0;
        status.up_stop      = !dhq_pkg::key_less(key_reg, rd_data_reg);
        status.last_is_root = count_reg == CW'(1);
        status.child_more   = c_reg < d_eff && child_idx < IW'(count_reg) - IW'(1);
        status.best_moved   = best_reg != pos_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(dhq_pkg::CAPACITY))
        else $error("entry count above capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_re && mem_we && mem_raddr == mem_waddr))
        else $error("read and write collide on one entry");
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(was_empty && overflow))
        else $error("empty and overflow together");

endmodule

// File: rtl/dhq_ctrl.sv
// dhq_ctrl: sequencer for push sift-up and pop sift-down.
// Depends on dhq_pkg.
module dhq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output dhq_pkg::dhq_cmd_t    cmd,
    input  dhq_pkg::dhq_status_t status
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DECIDE = 11'b00000000010,
        S_UP_RD  = 11'b00000000100,
        S_UP_CHK = 11'b00000001000,
        S_DN_RD  = 11'b00000010000,
        S_DN_LST = 11'b00000100000,
        S_LEVEL  = 11'b00001000000,
        S_C_RD   = 11'b00010000000,
        S_C_CMP  = 11'b00100000000,
        S_WRITE  = 11'b01000000000,
        S_FINISH = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   cmp_pend_reg, cmp_pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmp_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cmp_pend_reg <= cmp_pend_next;
        end
    end

    assign busy = state_reg != S_IDLE;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        cmp_pend_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!status.is_pop && !status.full)
                begin
                    cmd.up_start = 1'b1;
                    state_next   = S_UP_RD;
                end
                else if (status.is_pop && !status.empty)
                begin
                    // root is in the read register; grab it, read last entry
                    cmd.dn_start = 1'b1;
                    state_next   = S_DN_RD;
                end
                else
                    state_next = S_FINISH;
            end
            S_UP_RD:
            begin
                if (status.at_root)
                    state_next = S_WRITE;
                else
                begin
                    cmd.rd_parent = 1'b1;
                    state_next    = S_UP_CHK;
                end
            end
            S_UP_CHK:
            begin
                cmd.up_step = 1'b1;
                state_next  = status.up_stop ? S_WRITE : S_UP_RD;
            end
            S_DN_RD:
                state_next = S_DN_LST;
            S_DN_LST:
            begin
                cmd.dn_last = 1'b1;
                state_next  = status.last_is_root ? S_FINISH : S_LEVEL;
            end
            S_LEVEL:
            begin
                cmd.dn_level = 1'b1;
                state_next   = S_C_RD;
            end
            S_C_RD:
            begin
                cmd.dn_cmp = cmp_pend_reg;
                if (status.child_more)
                begin
                    cmd.rd_child  = 1'b1;
                    cmp_pend_next = 1'b1;
                end
                else
                    state_next = S_C_CMP;
            end
            S_C_CMP:
            begin
                if (status.best_moved)
                begin
                    cmd.dn_move = 1'b1;
                    state_next  = S_LEVEL;
                end
                else
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write_key = !(status.is_pop && status.last_is_root);
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |=> (state_reg == S_IDLE))
        else $error("finish not followed by idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.write_key, cmd.dn_move, cmd.up_step}) <= 1)
        else $error("more than one memory write source");

endmodule

// File: rtl/dary_min_heap_queue_unit.sv
// dary_min_heap_queue_unit: top level of the d-ary min-heap priority queue.
// Depends on dhq_pkg, dhq_ctrl, dhq_datapath.
//
// Usage:
//  - Command channel: a transaction is taken at a rising edge with start high
//    and busy low. command 0 pushes key_in, command 1 pops the smallest key.
//  - Result: done is high for exactly one cycle with key_out, was_empty,
//    overflow and entries_now. The receiver cannot stall; it must take it.
//  - Configuration: cfg_we with cfg_data writes the branching factor d (reset
//    2; below 2 acts as 2, above 8 acts as 8). Write only while idle.
//  - Sequence, with one memory access per cycle. Push: each parent is read
//    and moved down while it is greater than the key, which is written where
//    the climb stops. Pop: the root is taken, the last entry read and sifted
//    down level by level, reading each child present (at most d); a pop that
//    empties the heap writes nothing. Empty pop or full push: no heap change.
//  - busy also covers the done cycle, so the next transaction is taken at
//    the earliest in the cycle after done.
//  - Reset: asynchronous, clears the entry count and sets d to 2; heap contents
//    are left as they are and are only used below the entry count.
module dary_min_heap_queue_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        command,
    input  logic [dhq_pkg::KEY_W-1:0]   key_in,
    input  logic                        cfg_we,
    input  logic [dhq_pkg::D_W-1:0]     cfg_data,
    output logic                        done,
    output logic [dhq_pkg::KEY_W-1:0]   key_out,
    output logic                        was_empty,
    output logic                        overflow,
    output logic [dhq_pkg::COUNT_W-1:0] entries_now
);

    dhq_pkg::dhq_cmd_t    cmd;
    dhq_pkg::dhq_status_t status;
    logic                 ctrl_busy;
    logic                 start_ok;

    // controller only sees start while done is low
    assign start_ok = start && !done;

    dhq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_ok),
        .busy   (ctrl_busy),
        .cmd    (cmd),
        .status (status)
    );

    dhq_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .command      (command),
        .key_in       (key_in),
        .result_valid (done),
        .key_out      (key_out),
        .was_empty    (was_empty),
        .overflow     (overflow),
        .entries_now  (entries_now)
    );

    // busy covers the cycle the result is presented too
    assign busy = ctrl_busy || done;

endmodule
